/* rtl/core/pic_pkg.sv */
// Shared constants and types for the point-in-cylinder classifier.
package pic_pkg;

  // Chunk width of the split multipliers and their latency in cycles.
  localparam int MulChunk = 17;
  localparam int MulLat   = 5;

  // Input subtract, two multiplier pipelines, two sum stages and the compare.
  localparam int PipeDepth = 2 * MulLat + 4;

  localparam logic [1:0] PlaceOutside = 2'd0;
  localparam logic [1:0] PlaceBand    = 2'd1;
  localparam logic [1:0] PlaceInside  = 2'd2;

  typedef enum logic [2:0] {
    CfgBaseX       = 3'd0,
    CfgBaseY       = 3'd1,
    CfgBaseZ       = 3'd2,
    CfgAxisX       = 3'd3,
    CfgAxisY       = 3'd4,
    CfgAxisZ       = 3'd5,
    CfgOuterRadius = 3'd6,
    CfgInnerRadius = 3'd7
  } cfg_idx_e;

  // Outcome of the cap test: done means the placement is already settled.
  typedef struct packed {
    logic       done;
    logic [1:0] place;
  } cap_t;

endpackage

/* rtl/core/point_in_cylinder_classifier.sv */
// Top level of the point-in-cylinder classifier: configuration, pipeline control, output stage.
//
// The block classifies one signed fixed-point 3D point per clock against a finite cylinder
// given by base point, axis vector, outer and inner radius, all written through the
// configuration port while no point is in flight, a rule for the user that the block does not
// enforce. A point passes the input subtract, a pipelined multiplier for the axis and cross
// products, a sum stage, a second multiplier for the squared radial distance and scaled radii,
// a second sum stage, the final compare and the output register. A new point is accepted in
// every cycle while the skid register is empty; when the output is stalled, one more result is
// held in a skid register before the input side stalls. Configuration writes are always ready.
module point_in_cylinder_classifier
  import pic_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   placement_o
);

  localparam int N = COORD_BITS;
  localparam logic [N-1:0]   OneAxis   = N'(1) << FRAC_BITS;
  localparam logic [N-2:0]   OneRadius = (N-1)'(1) << FRAC_BITS;

  logic signed [N-1:0] base_q [3];
  logic signed [N-1:0] axis_q [3];
  logic [N-2:0]        outer_q;
  logic [N-2:0]        inner_q;
  logic signed [N-1:0] point [3];

  logic                 en;
  logic [PipeDepth-1:0] v_q;
  logic [1:0]           place_last;

  logic signed [2*N+2:0] s;
  logic signed [2*N+1:0] c;
  logic signed [2*N+1:0] cr [3];
  logic signed [2*N-1:0] ri2;
  logic signed [2*N-1:0] ro2;

  logic       out_valid_q;
  logic [1:0] out_q;
  logic       skid_valid_q;
  logic [1:0] skid_q;
  logic       out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        base_q[i] <= '0;
      end
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= OneAxis;
      outer_q   <= OneRadius;
      inner_q   <= OneRadius;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBaseX:       base_q[0] <= cfg_data_i;
        CfgBaseY:       base_q[1] <= cfg_data_i;
        CfgBaseZ:       base_q[2] <= cfg_data_i;
        CfgAxisX:       axis_q[0] <= cfg_data_i;
        CfgAxisY:       axis_q[1] <= cfg_data_i;
        CfgAxisZ:       axis_q[2] <= cfg_data_i;
        CfgOuterRadius: outer_q   <= cfg_data_i[N-2:0];
        CfgInnerRadius: inner_q   <= cfg_data_i[N-2:0];
        default:        outer_q   <= outer_q;
      endcase
    end
  end

  // The whole pipeline moves together; it halts only while the skid register is full.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign point[0] = point_x_i;
  assign point[1] = point_y_i;
  assign point[2] = point_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PipeDepth-2:0], in_valid_i};
    end
  end

  pic_front #(.COORD_BITS(N)) u_front (
    .clk_i          (clk_i),
    .en_i           (en),
    .point_i        (point),
    .base_i         (base_q),
    .axis_i         (axis_q),
    .outer_radius_i (outer_q),
    .inner_radius_i (inner_q),
    .s_o            (s),
    .c_o            (c),
    .cr_o           (cr),
    .ri2_o          (ri2),
    .ro2_o          (ro2)
  );

  pic_back #(.COORD_BITS(N)) u_back (
    .clk_i   (clk_i),
    .en_i    (en),
    .s_i     (s),
    .c_i     (c),
    .cr_i    (cr),
    .ri2_i   (ri2),
    .ro2_i   (ro2),
    .place_o (place_last)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= v_q[PipeDepth-1];
      end
    end else if (en && v_q[PipeDepth-1]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : place_last;
    end else if (en && v_q[PipeDepth-1]) begin
      skid_q <= place_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign placement_o = out_q;

endmodule

/* rtl/core/pic_mul.sv */
// Pipelined signed multiplier built from chunk-by-chunk partial products.
module pic_mul
  import pic_pkg::*;
#(
  parameter int WA = 32,
  parameter int WB = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] y_o
);

  localparam int NA = (WA + MulChunk - 1) / MulChunk;
  localparam int NB = (WB + MulChunk - 1) / MulChunk;
  localparam int AW = NA * MulChunk;
  localparam int BW = NB * MulChunk;
  localparam int PP = 2 * MulChunk;
  localparam int RW = (NB + 1) * MulChunk;
  localparam int PW = (NA + NB) * MulChunk;
  localparam int YW = WA + WB;

  logic [WA-1:0] mag_a;
  logic [WB-1:0] mag_b;
  logic [AW-1:0] ma_q;
  logic [BW-1:0] mb_q;
  logic [MulLat-2:0] neg_q;
  logic [PP-1:0] pp_q [NA][NB];
  logic [RW-1:0] row_d [NA];
  logic [RW-1:0] row_q [NA];
  logic [PW-1:0] prod_d;
  logic [PW-1:0] prod_q;
  logic signed [YW-1:0] y_q;

  // The negation of the most negative value wraps to its own magnitude.
  assign mag_a = a_i[WA-1] ? -a_i : a_i;
  assign mag_b = b_i[WB-1] ? -b_i : b_i;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * MulChunk));
      end
    end
  end

  always_comb begin
    prod_d = '0;
    for (int i = 0; i < NA; i++) begin
      prod_d = prod_d + (PW'(row_q[i]) << (i * MulChunk));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q     <= AW'(mag_a);
      mb_q     <= BW'(mag_b);
      neg_q[0] <= a_i[WA-1] ^ b_i[WB-1];
      for (int k = 1; k < MulLat - 1; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= PP'(ma_q[i*MulChunk +: MulChunk]) * PP'(mb_q[j*MulChunk +: MulChunk]);
        end
      end
      row_q  <= row_d;
      prod_q <= prod_d;
      y_q    <= neg_q[MulLat-2] ? -prod_q[YW-1:0] : prod_q[YW-1:0];
    end
  end

  assign y_o = y_q;

endmodule

/* rtl/core/pic_front.sv */
// Front half: offset from the base, first products, and the axial and cross sums.
module pic_front
  import pic_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_BITS-1:0]  point_i [3],
  input  logic signed [COORD_BITS-1:0]  base_i [3],
  input  logic signed [COORD_BITS-1:0]  axis_i [3],
  input  logic [COORD_BITS-2:0]         outer_radius_i,
  input  logic [COORD_BITS-2:0]         inner_radius_i,
  output logic signed [2*COORD_BITS+2:0] s_o,
  output logic signed [2*COORD_BITS+1:0] c_o,
  output logic signed [2*COORD_BITS+1:0] cr_o [3],
  output logic signed [2*COORD_BITS-1:0] ri2_o,
  output logic signed [2*COORD_BITS-1:0] ro2_o
);

  localparam int N   = COORD_BITS;
  localparam int SW  = 2 * N + 3;
  localparam int CW  = 2 * N + 2;
  localparam int AWP = 2 * N + 1;
  localparam int R2W = 2 * N;

  logic signed [N:0]     w_q [3];
  logic signed [AWP-1:0] aw [3][3];
  logic signed [R2W-1:0] aa [3];
  logic signed [N-1:0]   ri_s;
  logic signed [N-1:0]   ro_s;
  logic signed [R2W-1:0] ri2;
  logic signed [R2W-1:0] ro2;
  logic signed [SW-1:0]  s_q;
  logic signed [CW-1:0]  c_q;
  logic signed [CW-1:0]  cr_q [3];
  logic signed [R2W-1:0] ri2_q;
  logic signed [R2W-1:0] ro2_q;

  assign ri_s = $signed({1'b0, inner_radius_i});
  assign ro_s = $signed({1'b0, outer_radius_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= (N+1)'(point_i[i]) - (N+1)'(base_i[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    for (genvar j = 0; j < 3; j++) begin : g_w
      pic_mul #(.WA(N), .WB(N + 1)) u_aw (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (axis_i[i]),
        .b_i   (w_q[j]),
        .y_o   (aw[i][j])
      );
    end
    pic_mul #(.WA(N), .WB(N)) u_aa (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (axis_i[i]),
      .b_i   (axis_i[i]),
      .y_o   (aa[i])
    );
  end

  pic_mul #(.WA(N), .WB(N)) u_ri2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (ri_s),
    .b_i   (ri_s),
    .y_o   (ri2)
  );

  pic_mul #(.WA(N), .WB(N)) u_ro2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (ro_s),
    .b_i   (ro_s),
    .y_o   (ro2)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= SW'(aw[0][0]) + SW'(aw[1][1]) + SW'(aw[2][2]);
      c_q     <= CW'(aa[0]) + CW'(aa[1]) + CW'(aa[2]);
      cr_q[0] <= CW'(aw[1][2]) - CW'(aw[2][1]);
      cr_q[1] <= CW'(aw[2][0]) - CW'(aw[0][2]);
      cr_q[2] <= CW'(aw[0][1]) - CW'(aw[1][0]);
      ri2_q   <= ri2;
      ro2_q   <= ro2;
    end
  end

  assign s_o   = s_q;
  assign c_o   = c_q;
  assign cr_o  = cr_q;
  assign ri2_o = ri2_q;
  assign ro2_o = ro2_q;

endmodule

/* rtl/core/pic_back.sv */
// Back half: cap test, squared radial distance, scaled radii and the final compare.
module pic_back
  import pic_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [2*COORD_BITS+2:0] s_i,
  input  logic signed [2*COORD_BITS+1:0] c_i,
  input  logic signed [2*COORD_BITS+1:0] cr_i [3],
  input  logic signed [2*COORD_BITS-1:0] ri2_i,
  input  logic signed [2*COORD_BITS-1:0] ro2_i,
  output logic [1:0]                     place_o
);

  localparam int N   = COORD_BITS;
  localparam int SW  = 2 * N + 3;
  localparam int CW  = 2 * N + 2;
  localparam int R2W = 2 * N;
  localparam int QW  = 2 * CW;
  localparam int TW  = R2W + CW;
  localparam int DW  = 2 * CW + 2;

  logic signed [SW-1:0] c_ext;
  cap_t                 cap_d;
  cap_t                 cap_q [MulLat];
  cap_t                 cap2_q;
  logic signed [QW-1:0] sq [3];
  logic signed [TW-1:0] ti;
  logic signed [TW-1:0] to;
  logic signed [DW-1:0] d_q;
  logic signed [DW-1:0] ti_q;
  logic signed [DW-1:0] to_q;
  logic [1:0]           place_d;
  logic [1:0]           place_q;

  assign c_ext = SW'(c_i);

  always_comb begin
    cap_d.done  = 1'b1;
    cap_d.place = PlaceOutside;
    priority if (c_i == '0) begin
      cap_d.place = PlaceOutside;
    end else if (s_i < 0 || s_i > c_ext) begin
      cap_d.place = PlaceOutside;
    end else if (s_i == '0 || s_i == c_ext) begin
      cap_d.place = PlaceBand;
    end else begin
      cap_d.done = 1'b0;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    pic_mul #(.WA(CW), .WB(CW)) u_sq (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (cr_i[i]),
      .b_i   (cr_i[i]),
      .y_o   (sq[i])
    );
  end

  pic_mul #(.WA(R2W), .WB(CW)) u_ti (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (ri2_i),
    .b_i   (c_i),
    .y_o   (ti)
  );

  pic_mul #(.WA(R2W), .WB(CW)) u_to (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (ro2_i),
    .b_i   (c_i),
    .y_o   (to)
  );

  always_comb begin
    priority if (cap2_q.done) begin
      place_d = cap2_q.place;
    end else if (d_q >= ti_q && d_q < to_q) begin
      place_d = PlaceBand;
    end else if (d_q < ti_q) begin
      place_d = PlaceInside;
    end else begin
      place_d = PlaceOutside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cap_q[0] <= cap_d;
      for (int k = 1; k < MulLat; k++) begin
        cap_q[k] <= cap_q[k-1];
      end
      cap2_q  <= cap_q[MulLat-1];
      d_q     <= DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);
      ti_q    <= DW'(ti);
      to_q    <= DW'(to);
      place_q <= place_d;
    end
  end

  assign place_o = place_q;

endmodule

/* tb/point_in_cylinder_classifier_tb.sv */
// Self-checking testbench for the point-in-cylinder classifier: directed, random and stall tests.
`timescale 1ns / 100ps

module point_in_cylinder_classifier_tb;
  import pic_pkg::*;

  localparam int CoordBits   = 32;
  localparam int FracBits    = 16;
  localparam int ClkPeriod   = 4;
  localparam int ResetCycles = 8;
  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 105;

  localparam logic signed [31:0] One  = 32'sh0001_0000;
  localparam logic signed [31:0] Half = 32'sh0000_8000;
  localparam logic signed [31:0] MaxC = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinC = 32'sh8000_0000;
  localparam logic [31:0]        RadiusMask = 32'h7FFF_FFFF;

  typedef logic signed [159:0] wide_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic signed [CoordBits-1:0]  point_x_i;
  logic signed [CoordBits-1:0]  point_y_i;
  logic signed [CoordBits-1:0]  point_z_i;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [2:0]                   cfg_index_i;
  logic [CoordBits-1:0]         cfg_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [1:0]                   placement_o;

  logic [31:0] cfg_shadow [8];
  logic [1:0]  expected_place_q [$];
  logic [1:0]  want_place;
  int          place_count [4];
  int          points_sent;
  int          results_checked;
  int          cfg_writes;
  int          failures;
  int          quiet_cycles;
  int          stall_hold;
  int          idle_pct;

  point_in_cylinder_classifier #(
    .COORD_BITS(CoordBits),
    .FRAC_BITS (FracBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .placement_o(placement_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [1:0] classify(input logic signed [31:0] px, py, pz);
    wide_t ax, ay, az, wx, wy, wz, base, c, s, cx, cy, cz, radial, inner_sq, outer_sq;
    ax = wide_t'($signed(cfg_shadow[CfgAxisX]));
    ay = wide_t'($signed(cfg_shadow[CfgAxisY]));
    az = wide_t'($signed(cfg_shadow[CfgAxisZ]));
    wx = wide_t'(px);
    base = wide_t'($signed(cfg_shadow[CfgBaseX]));
    wx = wx - base;
    wy = wide_t'(py);
    base = wide_t'($signed(cfg_shadow[CfgBaseY]));
    wy = wy - base;
    wz = wide_t'(pz);
    base = wide_t'($signed(cfg_shadow[CfgBaseZ]));
    wz = wz - base;
    c = ax * ax + ay * ay + az * az;
    s = ax * wx + ay * wy + az * wz;
    if (c == 0) return PlaceOutside;
    if (s < 0 || s > c) return PlaceOutside;
    if (s == 0 || s == c) return PlaceBand;
    cx = ay * wz - az * wy;
    cy = az * wx - ax * wz;
    cz = ax * wy - ay * wx;
    radial = cx * cx + cy * cy + cz * cz;
    inner_sq = wide_t'(cfg_shadow[CfgInnerRadius][30:0]);
    outer_sq = wide_t'(cfg_shadow[CfgOuterRadius][30:0]);
    inner_sq = inner_sq * inner_sq * c;
    outer_sq = outer_sq * outer_sq * c;
    if (radial < inner_sq) return PlaceInside;
    if (radial < outer_sq) return PlaceBand;
    return PlaceOutside;
  endfunction

  function automatic logic signed [31:0] srand(input int bits);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (31 - bits);
  endfunction

  task automatic note_failure(input string msg);
    if (failures < 10) $display("MISMATCH: %s", msg);
    failures++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_place_q.size() == 0) begin
        note_failure($sformatf("placement %0d arrived with nothing pending", placement_o));
      end else begin
        want_place = expected_place_q.pop_front();
        if (placement_o !== want_place)
          note_failure($sformatf("result %0d: expected placement %0d, got %0d",
                                 results_checked, want_place, placement_o));
        place_count[want_place]++;
        results_checked++;
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_place_q.push_back(classify(point_x_i, point_y_i, point_z_i));
      points_sent++;
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no handshake for %0d cycles.", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      out_stall_i <= 1'b1;
      stall_hold--;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_point(input logic signed [31:0] x, y, z);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    point_z_i  <= z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_place_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgOuterRadius || idx == CfgInnerRadius) begin
      cfg_shadow[idx] = data & RadiusMask;
    end else begin
      cfg_shadow[idx] = data;
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_cylinder(input logic [31:0] bx, by, bz, ax, ay, az, outer, inner);
    wait_idle();
    write_reg(CfgBaseX, bx);
    write_reg(CfgBaseY, by);
    write_reg(CfgBaseZ, bz);
    write_reg(CfgAxisX, ax);
    write_reg(CfgAxisY, ay);
    write_reg(CfgAxisZ, az);
    write_reg(CfgOuterRadius, outer);
    write_reg(CfgInnerRadius, inner);
  endtask

  // Most points lie along the axis with noise on every coordinate; some sit exactly on a cap, the rest are random.
  task automatic send_near_point(input int noise_bits);
    int                 sel;
    int                 k;
    int                 i;
    logic signed [63:0] t;
    logic signed [31:0] p [3];
    sel = $urandom_range(99);
    if (sel < 20) begin
      send_point($urandom, $urandom, $urandom);
      return;
    end
    k = (sel < 28) ? (sel[0] ? 256 : 0) : int'($urandom_range(358)) - 51;
    for (i = 0; i < 3; i++) begin
      t = 64'($signed(cfg_shadow[CfgAxisX + i])) * 64'(k);
      p[i] = $signed(cfg_shadow[CfgBaseX + i]) + t[39:8];
      if (sel >= 28) p[i] = p[i] + srand(noise_bits);
    end
    send_point(p[0], p[1], p[2]);
  endtask

  task automatic test_reset_defaults();
    send_point(0, 0, Half);
    send_point(0, 0, 0);
    send_point(0, 0, One);
    send_point(0, 0, -1);
    send_point(One, 0, Half);
  endtask

  task automatic test_cylinder_cases();
    set_cylinder(One, 2 * One, 3 * One, 0, 0, 4 * One, 2 * One, One + Half);
    send_point(One + Half, 2 * One, 5 * One);
    send_point(32'sh0002_C000, 2 * One, 5 * One);
    send_point(4 * One, 2 * One, 5 * One);
    send_point(One, 2 * One, 2 * One);
    send_point(One, 2 * One, 8 * One);
    send_point(6 * One, 2 * One, 7 * One);
    send_point(One, 2 * One, 3 * One);
    send_point(MaxC, MaxC, MaxC);
    send_point(MinC, MinC, MinC);
    send_point(MaxC, MinC, 0);
    send_point(-1, -1, -1);
  endtask

  task automatic test_zero_axis();
    set_cylinder(One, One, One, 0, 0, 0, One, Half);
    send_point(One, One, One);
    send_point(srand(31), srand(31), srand(31));
  endtask

  task automatic test_inner_above_outer();
    set_cylinder(0, 0, 0, 0, 0, 4 * One, One, 3 * One);
    send_point(2 * One, 0, 2 * One);
    send_point(4 * One, 0, 2 * One);
    send_point(Half, 0, One);
  endtask

  task automatic test_wide_writes();
    set_cylinder(0, 0, 0, One, One, 0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_point(Half, Half, 0);
    send_point(One, 0, 1000 * One);
  endtask

  task automatic test_random_cylinders();
    int          ph;
    int          n;
    int          axis_bits;
    int          radius_bits;
    logic [31:0] outer;
    logic [31:0] inner;
    for (ph = 0; ph < 6; ph++) begin
      axis_bits   = 10 + 4 * ph;
      radius_bits = $urandom_range(6, (axis_bits > 29) ? 29 : axis_bits - 1);
      outer       = $urandom_range(0, 1 << radius_bits);
      case ($urandom_range(7))
        0:       inner = outer;
        1:       inner = outer + $urandom_range(0, outer);
        default: inner = outer >> $urandom_range(0, 3);
      endcase
      set_cylinder(srand(28), srand(28), srand(28),
                   srand(axis_bits), srand(axis_bits), srand(axis_bits),
                   outer | {$urandom_range(1) == 1, 31'd0},
                   inner | {$urandom_range(1) == 1, 31'd0});
      idle_pct = (ph == 2) ? 0 : 25;
      for (n = 0; n < PhaseItems; n++) send_near_point(radius_bits + 1);
    end
    idle_pct = 25;
  endtask

  task automatic test_extreme_config();
    int n;
    set_cylinder(MinC, MaxC, 0, MaxC, MinC, MaxC, RadiusMask, 0);
    for (n = 0; n < 40; n++) send_near_point(30);
    set_cylinder(srand(28), srand(28), srand(28), srand(20), srand(20), srand(20), 0, 0);
    for (n = 0; n < 30; n++) send_near_point(8);
  endtask

  task automatic test_backpressure();
    int n;
    set_cylinder(0, 0, 0, 0, 0, One, One, Half);
    idle_pct   = 0;
    stall_hold = HoldCycles;
    for (n = 0; n < 60; n++) send_near_point(17);
    idle_pct = 25;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    point_z_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgBaseX;
    cfg_data_i  = '0;
    idle_pct    = 25;
    stall_hold  = 0;
    foreach (cfg_shadow[i]) cfg_shadow[i] = '0;
    cfg_shadow[CfgAxisZ]       = One;
    cfg_shadow[CfgOuterRadius] = One;
    cfg_shadow[CfgInnerRadius] = One;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_cylinder_cases();
    test_zero_axis();
    test_inner_above_outer();
    test_wide_writes();
    test_random_cylinders();
    test_extreme_config();
    test_backpressure();

    wait_idle();
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (expected_place_q.size() != 0)
      note_failure($sformatf("%0d placements never arrived", expected_place_q.size()));

    $display("Sent %0d points and checked %0d results across %0d register writes.",
             points_sent, results_checked, cfg_writes);
    $display("Covered caps, zero axis, inverted radii, wide writes and a %0d-cycle %s",
             HoldCycles, $sformatf("output hold (out %0d, band %0d, in %0d).",
                                   place_count[PlaceOutside], place_count[PlaceBand],
                                   place_count[PlaceInside]));
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
